@@ hw/rtl/crcftc_pkg.sv @@
// Package for the CRC-32 frame trailer checker.
// Holds the CRC constants and the byte-wise CRC update; no dependencies.
`default_nettype none

package crcftc_pkg;

    localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES  = 32'hFFFF_FFFF;
    localparam int          CNT_W     = 3;
    localparam logic [CNT_W-1:0] COUNT_MAX  = CNT_W'(5);
    localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(4);
    localparam int          TRAILER_BYTES = 4;

    typedef logic [7:0]  byte_t;
    typedef logic [31:0] crc_t;

    // Reflected CRC-32, one byte in: eight shift/xor steps of plain logic.
    function automatic crc_t crc_feed_byte(input crc_t crc_in, input byte_t b);
        crc_t c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/crcftc_if.sv @@
// Valid/ready channels of the CRC-32 frame trailer checker.
// Depends on crcftc_pkg for the payload types.
`default_nettype none

interface crcftc_in_if;
    logic                 valid;
    logic                 ready;
    crcftc_pkg::byte_t    data_byte;
    logic                 end_of_frame;

    modport source (output valid, output data_byte, output end_of_frame, input ready);
    modport sink   (input valid, input data_byte, input end_of_frame, output ready);
endinterface

interface crcftc_out_if;
    logic                 valid;
    logic                 ready;
    logic                 frame_ok;
    logic                 too_short;
    crcftc_pkg::crc_t     computed_crc;
    crcftc_pkg::crc_t     received_crc;

    modport source (output valid, output frame_ok, output too_short,
                    output computed_crc, output received_crc, input ready);
    modport sink   (input valid, input frame_ok, input too_short,
                    input computed_crc, input received_crc, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/crc32_frame_trailer_check.sv @@
// CRC-32 frame trailer checker, top level.
// Depends on crcftc_pkg and the channel interfaces in crcftc_if.sv.
//
// Usage:
//   frame  : one beat per frame byte; end_of_frame marks the last byte. The
//            last four bytes are the received CRC, most significant first.
//   result : one beat per frame, after its last byte: frame_ok, too_short,
//            computed_crc (CRC-32 over the payload) and received_crc.
//   A byte is held in an input register and then processed; the result of a
//   frame is written into the result register once its final byte moves on
//   from the input register, and is taken there when result.ready is high.
//   Throughput is one byte per cycle while no final byte waits: the byte-wise
//   CRC update is a shallow xor network from input to state registers.
//   The result register holds a result until it is taken. While it is full,
//   non-final bytes keep flowing; a final byte waits in the input register
//   until the result beat completes.
//   Reset clears the CRC to all ones, the trailer delay and the byte count;
//   the same clear happens after every final byte. Frames shorter than five
//   bytes report too_short with frame_ok low.
`default_nettype none

module crc32_frame_trailer_check (
    input  wire logic         clk,
    input  wire logic         rst_n,
    crcftc_in_if.sink         frame,
    crcftc_out_if.source      result
);
    import crcftc_pkg::*;

    // input register
    logic        s1_valid_reg;
    byte_t       s1_byte_reg;
    logic        s1_eof_reg;

    // frame state
    crc_t              crc_reg;
    crc_t              crc_next;
    byte_t             delay_reg [TRAILER_BYTES];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    // result register
    logic        out_valid_reg;
    logic        ok_reg;
    logic        short_reg;
    crc_t        computed_reg;
    crc_t        received_reg;

    logic        s1_advance;
    logic        short_frame;
    crc_t        computed;
    crc_t        received;

    // A final byte may only move on when the result register is free or being taken.
    assign s1_advance  = s1_valid_reg && (!s1_eof_reg || !out_valid_reg || result.ready);
    assign frame.ready = !s1_valid_reg || s1_advance;

    assign short_frame = (count_reg < COUNT_FULL);
    assign crc_next    = short_frame ? crc_reg : crc_feed_byte(crc_reg, delay_reg[0]);
    assign count_next  = (count_reg < COUNT_MAX) ? count_reg + CNT_W'(1) : count_reg;
    assign computed    = crc_next ^ CRC_ONES;
    assign received    = {delay_reg[1], delay_reg[2], delay_reg[3], s1_byte_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (frame.ready)
        begin
            s1_valid_reg <= frame.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame.ready && frame.valid)
        begin
            s1_byte_reg <= frame.data_byte;
            s1_eof_reg  <= frame.end_of_frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= CRC_ONES;
            count_reg <= '0;
            for (int i = 0; i < TRAILER_BYTES; i++)
            begin
                delay_reg[i] <= '0;
            end
        end
        else if (s1_advance)
        begin
            if (s1_eof_reg)
            begin
                // drop all frame state after the final byte
                crc_reg   <= CRC_ONES;
                count_reg <= '0;
                for (int i = 0; i < TRAILER_BYTES; i++)
                begin
                    delay_reg[i] <= '0;
                end
            end
            else
            begin
                crc_reg   <= crc_next;
                count_reg <= count_next;
                for (int i = 0; i < TRAILER_BYTES - 1; i++)
                begin
                    delay_reg[i] <= delay_reg[i+1];
                end
                delay_reg[TRAILER_BYTES-1] <= s1_byte_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance && s1_eof_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_eof_reg)
        begin
            ok_reg       <= !short_frame && (computed == received);
            short_reg    <= short_frame;
            computed_reg <= computed;
            received_reg <= received;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.frame_ok     = ok_reg;
    assign result.too_short    = short_reg;
    assign result.computed_crc = computed_reg;
    assign result.received_crc = received_reg;

`ifndef SYNTHESIS
    a_short_not_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(ok_reg && short_reg))
        else $error("short frame reported as ok");

    a_short_crc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && short_reg) |-> (computed_reg == '0))
        else $error("short frame carries a nonzero computed CRC");

    a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && s1_eof_reg) |=> (crc_reg == CRC_ONES && count_reg == '0))
        else $error("frame state not cleared after final byte");

    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_MAX)
        else $error("byte count beyond saturation");
`endif

endmodule

`default_nettype wire
